// File: rtl/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// bdpc_pkg: shared types and constants of the button press classifier
// Register indexes, reset values of the setup registers and the structs
// that travel between the lanes, the combo timer and the top level.
// ----------------------------------------------------------------------------
package bdpc_pkg;

   localparam int TIME_W  = 32;
   localparam int CFG_W   = 16;
   localparam int FIELD_W = 4;
   localparam int INDEX_W = 2;

   typedef enum logic [INDEX_W-1:0] {
      CSR_DEBOUNCE   = 2'd0,
      CSR_LONG_PRESS = 2'd1,
      CSR_COMBO_HOLD = 2'd2
   } csr_index_type;

   localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
   localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;
   localparam logic [CFG_W-1:0] COMBO_HOLD_RESET = 16'd3000;

   typedef struct packed {
      logic [CFG_W-1:0] debounce_ms;
      logic [CFG_W-1:0] long_hold_ms;
      logic [CFG_W-1:0] combo_hold_ms;
   } cfg_type;

   typedef struct packed {
      logic short_hit;
      logic long_hit;
      logic held;
   } lane_result_type;

endpackage

// File: rtl/bdpc_if.sv
// ----------------------------------------------------------------------------
// bdpc channel interfaces
// Valid/ready channels for polls, results and setup register writes.
// ----------------------------------------------------------------------------
interface bdpc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_ms;
   logic [3:0]  raw_levels;
   modport source (output valid, output now_ms, output raw_levels, input ready);
   modport sink (input valid, input now_ms, input raw_levels, output ready);
endinterface

interface bdpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] short_press_mask;
   logic [3:0] long_press_mask;
   logic       combo_fired;
   logic [3:0] held_mask;
   modport source (output valid, output short_press_mask, output long_press_mask,
                   output combo_fired, output held_mask, input ready);
   modport sink (input valid, input short_press_mask, input long_press_mask,
                 input combo_fired, input held_mask, output ready);
endinterface

interface bdpc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/bdpc_lane.sv
// ----------------------------------------------------------------------------
// bdpc_lane: debounce and press timing for one button
// Tracks the raw and debounced level of one button and flags short and
// long presses for each poll it is stepped with.
// ----------------------------------------------------------------------------
module bdpc_lane
   import bdpc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 level,
   input  logic [TIME_W-1:0]    now_ms,
   input  cfg_type              cfg,
   output lane_result_type      result
);

   logic              stable_ff, stable_in;
   logic              prev_raw_ff;
   logic              long_rep_ff, long_rep_in;
   logic [TIME_W-1:0] change_time_ff, change_time_in;
   logic [TIME_W-1:0] press_start_ff, press_start_in;
   logic [TIME_W-1:0] since_change;
   logic [TIME_W-1:0] since_press;
   logic              settled;
   logic              reached_long;

   assign since_change = now_ms - change_time_ff;
   assign since_press  = now_ms - press_start_ff;
   // A fresh raw edge restarts the window, so it can never count as settled.
   assign settled      = (level == prev_raw_ff) &&
                         (since_change > {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms});
   assign reached_long = since_press >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_hold_ms};

   always_comb begin
      stable_in      = stable_ff;
      long_rep_in    = long_rep_ff;
      press_start_in = press_start_ff;
      change_time_in = (level != prev_raw_ff) ? now_ms : change_time_ff;
      result         = '0;
      if (step && settled) begin
         if (level != stable_ff) begin
            stable_in = level;
            if (!level) begin
               press_start_in = now_ms;
               long_rep_in    = 1'b0;
            end else if (!long_rep_ff && !reached_long) begin
               result.short_hit = 1'b1;
            end
         end else if (!level && !long_rep_ff && reached_long) begin
            long_rep_in     = 1'b1;
            result.long_hit = 1'b1;
         end
      end
      result.held = step ? !stable_in : !stable_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff      <= 1'b1;
         prev_raw_ff    <= 1'b1;
         long_rep_ff    <= 1'b0;
         change_time_ff <= '0;
         press_start_ff <= '0;
      end else if (step) begin
         stable_ff      <= stable_in;
         prev_raw_ff    <= level;
         long_rep_ff    <= long_rep_in;
         change_time_ff <= change_time_in;
         press_start_ff <= press_start_in;
      end
   end

endmodule

// File: rtl/bdpc_combo.sv
// ----------------------------------------------------------------------------
// bdpc_combo: two-button combo hold timer
// Times how long buttons zero and one are both raw-pressed and fires once
// per hold when the hold time is reached.
// ----------------------------------------------------------------------------
module bdpc_combo
   import bdpc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              both_low,
   input  logic [TIME_W-1:0] now_ms,
   input  logic [CFG_W-1:0]  combo_hold_ms,
   output logic              fire
);

   logic              running_ff;
   logic              reported_ff;
   logic [TIME_W-1:0] start_ff;
   logic [TIME_W-1:0] held_for;

   assign held_for = now_ms - start_ff;
   // The first poll of a hold only starts the timer.
   assign fire = both_low && running_ff && !reported_ff &&
                 (held_for >= {{(TIME_W-CFG_W){1'b0}}, combo_hold_ms});

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff  <= 1'b0;
         reported_ff <= 1'b0;
         start_ff    <= '0;
      end else if (step) begin
         if (!both_low) begin
            running_ff  <= 1'b0;
            reported_ff <= 1'b0;
         end else if (!running_ff) begin
            running_ff  <= 1'b1;
            reported_ff <= 1'b0;
            start_ff    <= now_ms;
         end else if (fire) begin
            reported_ff <= 1'b1;
         end
      end
   end

endmodule

// File: rtl/button_debounce_press_classifier_unit.sv
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_unit: debounced button press classifier
// Debounces up to BUTTON_COUNT buttons in parallel lanes, reports short and
// long presses and a two-button combo hold for every poll.
//
// Usage:
//   req carries one poll per item: a millisecond timestamp and the raw
//   active-low levels of four buttons. Every poll yields exactly one item
//   on rsp with the short-press, long-press and held masks and the combo
//   flag. csr writes the debounce, long-press and combo hold times by
//   register index; it is always ready and should only be written while
//   no poll is in flight.
//   A poll's result appears on rsp in the cycle after the poll is accepted.
//   Throughput is one poll per cycle while rsp is ready: every lane and the combo timer finish
//   their compares and state update in the cycle the poll is accepted, and
//   the result sits in an output register.
//   When rsp stalls, the result is held and req accepts a new poll only in
//   a cycle where the output register is empty or being emptied.
//   Reset (synchronous) restores the default times, marks every button as
//   released, clears the combo timer and empties the output register.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_unit
   import bdpc_pkg::*;
#(
   parameter int BUTTON_COUNT = 4
)
(
   input  logic       clock,
   input  logic       reset,
   bdpc_req_if.sink   req_chan,
   bdpc_rsp_if.source rsp_chan,
   bdpc_csr_if.sink   csr_chan
);

   cfg_type                  cfg_ff;
   logic                     accept;
   logic                     combo_poll;
   logic                     lane_step;
   logic                     combo_fire;
   lane_result_type          lane_res [BUTTON_COUNT];
   logic [FIELD_W-1:0]       short_in, long_in, held_in;
   logic                     rsp_valid_ff;
   logic [FIELD_W-1:0]       short_ff, long_ff, held_ff;
   logic                     combo_ff;

   assign accept     = req_chan.valid && req_chan.ready;
   assign combo_poll = (req_chan.raw_levels[1:0] == 2'b00);
   assign lane_step  = accept && !combo_poll;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= DEBOUNCE_RESET;
         cfg_ff.long_hold_ms  <= LONG_PRESS_RESET;
         cfg_ff.combo_hold_ms <= COMBO_HOLD_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_DEBOUNCE:   cfg_ff.debounce_ms   <= csr_chan.data;
            CSR_LONG_PRESS: cfg_ff.long_hold_ms  <= csr_chan.data;
            CSR_COMBO_HOLD: cfg_ff.combo_hold_ms <= csr_chan.data;
            default: ;
         endcase
      end
   end

   bdpc_combo u_combo (
      .clock         (clock),
      .reset         (reset),
      .step          (accept),
      .both_low      (combo_poll),
      .now_ms        (req_chan.now_ms),
      .combo_hold_ms (cfg_ff.combo_hold_ms),
      .fire          (combo_fire)
   );

   for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_lane
      logic level;
      // Buttons beyond the input field always read as released.
      if (i < FIELD_W) begin : g_wired
         assign level = req_chan.raw_levels[i];
      end else begin : g_idle
         assign level = 1'b1;
      end
      bdpc_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .step   (lane_step),
         .level  (level),
         .now_ms (req_chan.now_ms),
         .cfg    (cfg_ff),
         .result (lane_res[i])
      );
   end

   // Merge: gather the lanes that fit in the result fields.
   for (genvar b = 0; b < FIELD_W; b++) begin : g_merge
      if (b < BUTTON_COUNT) begin : g_used
         assign short_in[b] = lane_res[b].short_hit;
         assign long_in[b]  = lane_res[b].long_hit;
         assign held_in[b]  = lane_res[b].held;
      end else begin : g_unused
         assign short_in[b] = 1'b0;
         assign long_in[b]  = 1'b0;
         assign held_in[b]  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         short_ff <= short_in;
         long_ff  <= long_in;
         held_ff  <= held_in;
         combo_ff <= combo_fire;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.short_press_mask = short_ff;
   assign rsp_chan.long_press_mask  = long_ff;
   assign rsp_chan.combo_fired      = combo_ff;
   assign rsp_chan.held_mask        = held_ff;

endmodule

// File: bench/button_debounce_press_classifier_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_unit_tb: self-checking bench
// Sends timestamped button polls through the request channel and checks
// every result item against a cycle-free model of the debouncer, the
// press classifier and the combo timer. The timing registers are rewritten
// between phases, the extremes and zero among them.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_unit_tb
   import bdpc_pkg::*;
();

   typedef struct packed {
      logic [FIELD_W-1:0] short_mask;
      logic [FIELD_W-1:0] long_mask;
      logic               combo;
      logic [FIELD_W-1:0] held;
   } poll_result_type;

   class press_scoreboard;
      logic [CFG_W-1:0]   debounce_ms;
      logic [CFG_W-1:0]   long_hold_ms;
      logic [CFG_W-1:0]   combo_hold_ms;
      logic [FIELD_W-1:0] settled_lvl;
      logic [FIELD_W-1:0] last_raw;
      logic [FIELD_W-1:0] long_done;
      logic [TIME_W-1:0]  change_at [FIELD_W];
      logic [TIME_W-1:0]  press_at [FIELD_W];
      logic [TIME_W-1:0]  combo_at;
      logic               combo_on;
      logic               combo_done;
      poll_result_type    expected_q [$];
      int                 mismatch_count;
      int                 poll_count;
      int                 short_total;
      int                 long_total;
      int                 combo_total;

      function new();
         debounce_ms    = DEBOUNCE_RESET;
         long_hold_ms   = LONG_PRESS_RESET;
         combo_hold_ms  = COMBO_HOLD_RESET;
         settled_lvl    = '1;
         last_raw       = '1;
         long_done      = '0;
         foreach (change_at[i]) begin
            change_at[i] = '0;
            press_at[i]  = '0;
         end
         combo_at       = '0;
         combo_on       = 1'b0;
         combo_done     = 1'b0;
         mismatch_count = 0;
         poll_count     = 0;
         short_total    = 0;
         long_total     = 0;
         combo_total    = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [CFG_W-1:0] val);
         case (idx)
            CSR_DEBOUNCE:   debounce_ms   = val;
            CSR_LONG_PRESS: long_hold_ms  = val;
            CSR_COMBO_HOLD: combo_hold_ms = val;
            default: ;
         endcase
      endfunction

      function void note_poll(logic [TIME_W-1:0] now, logic [FIELD_W-1:0] raw);
         poll_result_type   exp;
         logic [TIME_W-1:0] since;
         logic              lvl;
         exp = '0;
         if (raw[1:0] == 2'b00) begin
            // Buttons 0 and 1 down together freeze all per-button state.
            if (!combo_on) begin
               combo_on   = 1'b1;
               combo_done = 1'b0;
               combo_at   = now;
            end else begin
               since = now - combo_at;
               if (!combo_done && since >= TIME_W'(combo_hold_ms)) begin
                  combo_done = 1'b1;
                  exp.combo  = 1'b1;
               end
            end
         end else begin
            combo_on   = 1'b0;
            combo_done = 1'b0;
            for (int i = 0; i < FIELD_W; i++) begin
               lvl = raw[i];
               if (lvl != last_raw[i])
                  change_at[i] = now;
               since = now - change_at[i];
               if (since > TIME_W'(debounce_ms)) begin
                  if (lvl != settled_lvl[i]) begin
                     settled_lvl[i] = lvl;
                     if (!lvl) begin
                        press_at[i]  = now;
                        long_done[i] = 1'b0;
                     end else begin
                        since = now - press_at[i];
                        if (!long_done[i] && since < TIME_W'(long_hold_ms))
                           exp.short_mask[i] = 1'b1;
                     end
                  end else if (!lvl && !long_done[i]) begin
                     since = now - press_at[i];
                     if (since >= TIME_W'(long_hold_ms)) begin
                        long_done[i]     = 1'b1;
                        exp.long_mask[i] = 1'b1;
                     end
                  end
               end
               last_raw[i] = lvl;
            end
         end
         exp.held = ~settled_lvl;
         poll_count++;
         short_total += $countones(exp.short_mask);
         long_total  += $countones(exp.long_mask);
         combo_total += exp.combo;
         expected_q.push_back(exp);
      endfunction

      function void check_result(poll_result_type got);
         poll_result_type exp;
         if (expected_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: result item with no poll waiting: %s",
                        $realtime,
                        $sformatf("short=%h long=%h combo=%b held=%h",
                                  got.short_mask, got.long_mask, got.combo, got.held));
         end else begin
            exp = expected_q.pop_front();
            if (got.short_mask !== exp.short_mask || got.long_mask !== exp.long_mask ||
                got.combo !== exp.combo || got.held !== exp.held) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: expected short=%h long=%h combo=%b held=%h, %s",
                           $realtime, exp.short_mask, exp.long_mask, exp.combo, exp.held,
                           $sformatf("got short=%h long=%h combo=%b held=%h",
                                     got.short_mask, got.long_mask, got.combo, got.held));
            end
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   int                send_idle_pct;
   int                recv_stall_pct;
   logic [TIME_W-1:0] cur_time;
   logic [FIELD_W-1:0] hold_pattern;
   press_scoreboard   sb = new();

   bdpc_req_if req_if ();
   bdpc_rsp_if rsp_if ();
   bdpc_csr_if csr_if ();

   button_debounce_press_classifier_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Accepted polls are noted before results are checked, so the queue
   // stays in order whatever the latency.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            sb.note_poll(req_if.now_ms, req_if.raw_levels);
         if (rsp_if.valid && rsp_if.ready)
            sb.check_result({rsp_if.short_press_mask, rsp_if.long_press_mask,
                             rsp_if.combo_fired, rsp_if.held_mask});
         if (csr_if.valid && csr_if.ready)
            sb.write_register(csr_index_type'(csr_if.index), csr_if.data);
      end
   end

   task automatic send_poll(logic [TIME_W-1:0] now, logic [FIELD_W-1:0] raw);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid      <= 1'b1;
      req_if.now_ms     <= now;
      req_if.raw_levels <= raw;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic drain_polls();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sb.expected_q.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CFG_W-1:0] val);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic run_directed();
      // Press and release of one button, including a hold of exactly the
      // debounce time, which must not be accepted yet.
      send_poll(32'd0, 4'hF);
      send_poll(32'd100, 4'hB);
      send_poll(32'd150, 4'hB);
      send_poll(32'd151, 4'hB);
      send_poll(32'd300, 4'hF);
      send_poll(32'd351, 4'hF);
      // Long press one poll short of and then at the threshold.
      send_poll(32'd400, 4'h7);
      send_poll(32'd451, 4'h7);
      send_poll(32'd1450, 4'h7);
      send_poll(32'd1451, 4'h7);
      send_poll(32'd1600, 4'hF);
      send_poll(32'd1651, 4'hF);
      // Combo hold, then release of one of its buttons.
      send_poll(32'd2000, 4'hC);
      send_poll(32'd4999, 4'hC);
      send_poll(32'd5000, 4'hC);
      send_poll(32'd6100, 4'hD);
      // Contact bounce restarts the debounce window.
      send_poll(32'd7000, 4'hE);
      send_poll(32'd7010, 4'hF);
      send_poll(32'd7020, 4'hE);
      send_poll(32'd7060, 4'hE);
      send_poll(32'd7071, 4'hE);
      send_poll(32'd7131, 4'hF);
      // Combo across the timestamp wrap, then time running backward.
      send_poll(32'hFFFF_FFF0, 4'h0);
      send_poll(32'h0000_0BA8, 4'h0);
      send_poll(32'hFFFF_FFFF, 4'hF);
      cur_time = 32'hFFFF_FFFF;
   endtask

   task automatic run_random(int count, int span);
      logic [FIELD_W-1:0] raw;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 3)
            cur_time = $urandom_range(0, 1) ? $urandom :
                       32'hFFFF_FFFF - $urandom_range(0, 4 * span);
         else
            cur_time += $urandom_range(0, span);
         if ($urandom_range(0, 99) < 8)
            hold_pattern = FIELD_W'($urandom_range(0, 15));
         raw = hold_pattern;
         if ($urandom_range(0, 99) < 10)
            raw ^= FIELD_W'($urandom_range(1, 15));
         send_poll(cur_time, raw);
      end
   endtask

   initial begin
      int deb [6];
      int lpr [6];
      int cmb [6];
      int span [6];
      deb  = '{50, 0, 65535, 0, 20, 0};
      lpr  = '{1000, 1, 65535, 0, 300, 1};
      cmb  = '{3000, 1, 65535, 0, 700, 1};
      span = '{150, 3, 30000, 3, 60, 10};
      deb[5]  = $urandom_range(0, 300);
      lpr[5]  = $urandom_range(1, 3000);
      cmb[5]  = $urandom_range(1, 6000);
      span[5] = deb[5] / 2 + lpr[5] / 10 + 2;

      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.now_ms     = '0;
      req_if.raw_levels = '1;
      rsp_if.ready      = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.index      = CSR_DEBOUNCE;
      csr_if.data       = '0;
      send_idle_pct     = 35;
      recv_stall_pct    = 72;
      cur_time          = '0;
      hold_pattern      = '1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      for (int p = 0; p < 6; p++) begin
         drain_polls();
         if (p == 2) begin
            send_idle_pct  = 72;
            recv_stall_pct = 35;
         end else if (p == 4) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         write_csr(CSR_DEBOUNCE, CFG_W'(deb[p]));
         write_csr(CSR_LONG_PRESS, CFG_W'(lpr[p]));
         write_csr(CSR_COMBO_HOLD, CFG_W'(cmb[p]));
         run_random(110, span[p]);
      end
      drain_polls();

      $display("Ran %0d polls under reset timing and six register setups,",
               sb.poll_count);
      $display("with stalls on both sides: %0d short, %0d long, %0d combo; %0d mismatches.",
               sb.short_total, sb.long_total, sb.combo_total, sb.mismatch_count);
      if (sb.mismatch_count == 0 && sb.expected_q.size() == 0)
         $display("button_debounce_press_classifier_unit: match");
      else
         $display("button_debounce_press_classifier_unit: mismatch");
      $finish;
   end

   initial begin
      #2400000;
      $display("Run did not finish in time; %0d results still outstanding.",
               sb.expected_q.size());
      $display("button_debounce_press_classifier_unit: mismatch");
      $finish;
   end

endmodule
